// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPLY(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

// next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NEXT(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/tlci_pkg.sv =====
`default_nettype none

package tlci_pkg;

    // default sizing
    localparam int TLCI_TEXT_DEPTH  = 65536;
    localparam int TLCI_BLOCK_SHIFT = 8;

    // command codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // line end characters
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // command transfer
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  text_byte;
        logic [31:0] query_offset;
    } cmd_t;

    // result transfer
    typedef struct packed {
        logic [16:0] line_number;
        logic [31:0] column_number;
    } res_t;

    // query sequencer states
    typedef enum logic [1:0] {
        SC_IDLE,
        SC_LOAD,
        SC_SCAN,
        SC_EMIT
    } scan_state_t;

endpackage

`default_nettype wire

// ===== design/tlci_ram.sv =====
`default_nettype none

module tlci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/tlci_track.sv =====
`default_nettype none

module tlci_track #(
    parameter int TEXT_DEPTH  = 65536,
    parameter int BLOCK_SHIFT = 8,
    localparam int LEN_W      = $clog2(TEXT_DEPTH + 1),
    localparam int ADDR_W     = $clog2(TEXT_DEPTH),
    localparam int CKPT_DEPTH = (TEXT_DEPTH >> BLOCK_SHIFT) + 1,
    localparam int CKPT_AW    = (CKPT_DEPTH > 1) ? $clog2(CKPT_DEPTH) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               clear,
    input  wire logic               append,
    input  wire logic [7:0]         text_byte,
    output logic                    text_we,
    output logic [ADDR_W-1:0]       text_waddr,
    output logic [7:0]              text_wdata,
    output logic                    ckpt_we,
    output logic [CKPT_AW-1:0]      ckpt_waddr,
    output logic [2*LEN_W-1:0]      ckpt_wdata,
    output logic [LEN_W-1:0]        len,
    output logic [LEN_W-1:0]        lines,
    output logic [LEN_W-1:0]        start,
    output logic                    pcr
);

    import tlci_pkg::*;

    localparam logic [LEN_W-1:0] LOW_MASK = LEN_W'((1 << BLOCK_SHIFT) - 1);
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(TEXT_DEPTH);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] lines_reg, lines_next;
    logic [LEN_W-1:0] start_reg, start_next;
    logic             pcr_reg, pcr_next;
    logic             take;
    logic             cr_end;
    logic [LEN_W-1:0] lines_mid;
    logic [LEN_W-1:0] start_mid;

    // running line state as each byte lands
    always_comb
    begin
        take      = append && (len_reg != FULL_LEN);
        cr_end    = pcr_reg && (text_byte != CH_LF);
        lines_mid = cr_end ? lines_reg + LEN_W'(1) : lines_reg;
        start_mid = cr_end ? len_reg : start_reg;

        len_next   = len_reg;
        lines_next = lines_reg;
        start_next = start_reg;
        pcr_next   = pcr_reg;

        if (clear)
        begin
            len_next   = '0;
            lines_next = '0;
            start_next = '0;
            pcr_next   = 1'b0;
        end
        else if (take)
        begin
            len_next = len_reg + LEN_W'(1);
            if (text_byte == CH_LF)
            begin
                lines_next = lines_mid + LEN_W'(1);
                start_next = len_reg + LEN_W'(1);
                pcr_next   = 1'b0;
            end
            else
            begin
                lines_next = lines_mid;
                start_next = start_mid;
                pcr_next   = (text_byte == CH_CR);
            end
        end
    end

    // byte store write and checkpoint at each block boundary
    always_comb
    begin
        text_we    = take;
        text_waddr = ADDR_W'(len_reg);
        text_wdata = text_byte;
        ckpt_we    = take && ((len_reg & LOW_MASK) == '0);
        ckpt_waddr = CKPT_AW'(len_reg >> BLOCK_SHIFT);
        ckpt_wdata = {lines_mid, start_mid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            lines_reg <= '0;
            start_reg <= '0;
            pcr_reg   <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            lines_reg <= lines_next;
            start_reg <= start_next;
            pcr_reg   <= pcr_next;
        end
    end

    assign len   = len_reg;
    assign lines = lines_reg;
    assign start = start_reg;
    assign pcr   = pcr_reg;

endmodule

`default_nettype wire

// ===== design/tlci_scan.sv =====
`default_nettype none

module tlci_scan #(
    parameter int TEXT_DEPTH  = 65536,
    parameter int BLOCK_SHIFT = 8,
    localparam int LEN_W      = $clog2(TEXT_DEPTH + 1),
    localparam int ADDR_W     = $clog2(TEXT_DEPTH),
    localparam int CKPT_DEPTH = (TEXT_DEPTH >> BLOCK_SHIFT) + 1,
    localparam int CKPT_AW    = (CKPT_DEPTH > 1) ? $clog2(CKPT_DEPTH) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                query,
    input  wire logic [31:0]         offset,
    input  wire logic [LEN_W-1:0]    len,
    input  wire logic [LEN_W-1:0]    lines,
    input  wire logic [LEN_W-1:0]    start,
    input  wire logic                pcr,
    output logic                     busy,
    output logic [ADDR_W-1:0]        text_raddr,
    input  wire logic [7:0]          text_rdata,
    output logic [CKPT_AW-1:0]       ckpt_raddr,
    input  wire logic [2*LEN_W-1:0]  ckpt_rdata,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output tlci_pkg::res_t           res
);

    import tlci_pkg::*;

    localparam logic [LEN_W-1:0] LOW_MASK = LEN_W'((1 << BLOCK_SHIFT) - 1);

    scan_state_t      state_reg, state_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;
    logic [31:0]      offset_reg, offset_next;
    logic [LEN_W-1:0] end_reg, end_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] line_reg, line_next;
    logic [LEN_W-1:0] lstart_reg, lstart_next;
    logic [7:0]       prev_reg, prev_next;
    logic [LEN_W-1:0] end_in;
    logic [LEN_W-1:0] base_in;
    logic             line_break;
    logic             res_load;
    logic [31:0]      start_wide;

    // clamp the offset to the text and find its block
    always_comb
    begin
        end_in     = (offset < 32'(len)) ? LEN_W'(offset) : len;
        base_in    = end_in & ~LOW_MASK;
        ckpt_raddr = CKPT_AW'(end_in >> BLOCK_SHIFT);
        text_raddr = (state_reg == SC_IDLE) ? ADDR_W'(base_in) : ADDR_W'(pos_reg + LEN_W'(1));
        line_break = (prev_reg == CH_LF) || ((prev_reg == CH_CR) && (text_rdata != CH_LF));
        start_wide = 32'(lstart_reg);
        res_load   = !res_valid_reg || !res_stall;
    end

    // sequencer: checkpoint load, byte scan, result hand-off
    always_comb
    begin
        state_next     = state_reg;
        offset_next    = offset_reg;
        end_next       = end_reg;
        pos_next       = pos_reg;
        line_next      = line_reg;
        lstart_next    = lstart_reg;
        prev_next      = prev_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        case (state_reg)
            SC_IDLE:
            begin
                if (query)
                begin
                    offset_next = offset;
                    end_next    = end_in;
                    pos_next    = base_in;
                    if (end_in == len)
                    begin
                        line_next   = lines + LEN_W'(pcr);
                        lstart_next = pcr ? len : start;
                        state_next  = SC_EMIT;
                    end
                    else
                    begin
                        state_next = SC_LOAD;
                    end
                end
            end
            SC_LOAD:
            begin
                line_next   = ckpt_rdata[2*LEN_W-1:LEN_W];
                lstart_next = ckpt_rdata[LEN_W-1:0];
                prev_next   = text_rdata;
                if (pos_reg == end_reg)
                begin
                    state_next = SC_EMIT;
                end
                else
                begin
                    pos_next   = pos_reg + LEN_W'(1);
                    state_next = SC_SCAN;
                end
            end
            SC_SCAN:
            begin
                // byte at pos_reg decides whether the previous byte ends a line
                if (line_break)
                begin
                    line_next   = line_reg + LEN_W'(1);
                    lstart_next = pos_reg;
                end
                prev_next = text_rdata;
                if (pos_reg == end_reg)
                begin
                    state_next = SC_EMIT;
                end
                else
                begin
                    pos_next = pos_reg + LEN_W'(1);
                end
            end
            SC_EMIT:
            begin
                if (res_load)
                begin
                    res_next.line_number   = 17'(line_reg);
                    res_next.column_number = (offset_reg > start_wide) ?
                                             offset_reg - start_wide : 32'd0;
                    res_valid_next = 1'b1;
                    state_next     = SC_IDLE;
                end
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SC_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        end_reg    <= end_next;
        pos_reg    <= pos_next;
        line_reg   <= line_next;
        lstart_reg <= lstart_next;
        prev_reg   <= prev_next;
        res_reg    <= res_next;
    end

    assign busy      = (state_reg != SC_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== design/text_line_column_index.sv =====
`default_nettype none

// Line and column index over a Latin-1 text. Op clear starts a new text and op append adds
// one byte; bytes stream in at one per cycle while no query stalls the commands. Op query
// returns the zero-based line and column of a byte offset. A query at or past the end of
// the text goes straight from idle to the result state. Any other query reloads the
// checkpoint of the block holding the offset and rescans the text memory one byte per
// cycle through its single read port, from the block start up to the offset. Commands
// stall during a query; a finished result waits in an output register, and appends and
// clears are still taken while it waits. Text and checkpoint memories are not cleared
// after reset and need no clearing pass.
module text_line_column_index #(
    parameter int TEXT_DEPTH  = tlci_pkg::TLCI_TEXT_DEPTH,
    parameter int BLOCK_SHIFT = tlci_pkg::TLCI_BLOCK_SHIFT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire tlci_pkg::cmd_t cmd,
    output logic                res_valid,
    input  wire logic           res_stall,
    output tlci_pkg::res_t      res
);

    import tlci_pkg::*;

    localparam int LEN_W      = $clog2(TEXT_DEPTH + 1);
    localparam int ADDR_W     = $clog2(TEXT_DEPTH);
    localparam int CKPT_DEPTH = (TEXT_DEPTH >> BLOCK_SHIFT) + 1;
    localparam int CKPT_AW    = (CKPT_DEPTH > 1) ? $clog2(CKPT_DEPTH) : 1;

    logic                 accept;
    logic                 do_clear;
    logic                 do_append;
    logic                 do_query;
    logic                 text_we;
    logic [ADDR_W-1:0]    text_waddr;
    logic [7:0]           text_wdata;
    logic [ADDR_W-1:0]    text_raddr;
    logic [7:0]           text_rdata;
    logic                 ckpt_we;
    logic [CKPT_AW-1:0]   ckpt_waddr;
    logic [2*LEN_W-1:0]   ckpt_wdata;
    logic [CKPT_AW-1:0]   ckpt_raddr;
    logic [2*LEN_W-1:0]   ckpt_rdata;
    logic [LEN_W-1:0]     len;
    logic [LEN_W-1:0]     lines;
    logic [LEN_W-1:0]     start;
    logic                 pcr;
    logic                 busy;

    // command decode on transfer
    assign accept    = cmd_valid && !cmd_stall;
    assign do_clear  = accept && (cmd.op == OP_CLEAR);
    assign do_append = accept && (cmd.op == OP_APPEND);
    assign do_query  = accept && (cmd.op == OP_QUERY);
    assign cmd_stall = busy;

    tlci_track #(
        .TEXT_DEPTH  (TEXT_DEPTH),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (do_clear),
        .append     (do_append),
        .text_byte  (cmd.text_byte),
        .text_we    (text_we),
        .text_waddr (text_waddr),
        .text_wdata (text_wdata),
        .ckpt_we    (ckpt_we),
        .ckpt_waddr (ckpt_waddr),
        .ckpt_wdata (ckpt_wdata),
        .len        (len),
        .lines      (lines),
        .start      (start),
        .pcr        (pcr)
    );

    tlci_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .clk   (clk),
        .we    (text_we),
        .waddr (text_waddr),
        .wdata (text_wdata),
        .raddr (text_raddr),
        .rdata (text_rdata)
    );

    tlci_ram #(
        .WIDTH (2 * LEN_W),
        .DEPTH (CKPT_DEPTH)
    ) u_ckpt_ram (
        .clk   (clk),
        .we    (ckpt_we),
        .waddr (ckpt_waddr),
        .wdata (ckpt_wdata),
        .raddr (ckpt_raddr),
        .rdata (ckpt_rdata)
    );

    tlci_scan #(
        .TEXT_DEPTH  (TEXT_DEPTH),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (do_query),
        .offset     (cmd.query_offset),
        .len        (len),
        .lines      (lines),
        .start      (start),
        .pcr        (pcr),
        .busy       (busy),
        .text_raddr (text_raddr),
        .text_rdata (text_rdata),
        .ckpt_raddr (ckpt_raddr),
        .ckpt_rdata (ckpt_rdata),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

`default_nettype wire

// ===== design/tlci_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module tlci_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire logic           cmd_stall,
    input  wire tlci_pkg::cmd_t cmd,
    input  wire logic           res_valid,
    input  wire logic           res_stall,
    input  wire tlci_pkg::res_t res
);

    import tlci_pkg::*;

    logic cmd_xfer;

    assign cmd_xfer = cmd_valid && !cmd_stall;

    // a stalled result holds
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res))

    // a taken query always leaves the sequencer busy, stalling commands
    `ASSERT_NEXT(a_query_stalls, clk, rst_n, cmd_xfer && (cmd.op == OP_QUERY), cmd_stall)

    // clear, append and unused codes never stall the next command
    `ASSERT_NEXT(a_stream_free, clk, rst_n, cmd_xfer && (cmd.op != OP_QUERY), !cmd_stall)

    // a new result appears only at the end of a query
    `ASSERT_IMPLY(a_res_after_query, clk, rst_n, $rose(res_valid), $past(cmd_stall))

endmodule

bind text_line_column_index tlci_checker u_checker (.*);

`default_nettype wire
